### rtl/frls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash record log scanner package
// Shared constants, result codes and result item types.
// ----------------------------------------------------------------------------
package frls_pkg;

	localparam int SECTOR_BYTES_DEF = 4096;
	localparam int OUT_W            = 13;
	localparam int HDR_BYTES        = 4;
	localparam int MIN_KEY          = 2;
	localparam logic [31:0] END_WORD = 32'hFFFF_FFFF;
	localparam int QDEPTH           = 4;
	localparam int TDATA_W          = 56;

	typedef enum logic [1:0] {
		KIND_RECORD  = 2'd0,
		KIND_END     = 2'd1,
		KIND_CORRUPT = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [OUT_W-1:0]   record_offset;
		logic [OUT_W-1:0]   key_length;
		logic [OUT_W-1:0]   value_length;
		logic               removed;
		logic [OUT_W-1:0]   free_bytes;
		logic               last;
	} res_t;

	typedef struct packed {
		logic v0;
		res_t r0;
		logic v1;
		res_t r1;
	} push_t;

endpackage

### rtl/frls_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record parser
// Holds the scan state and turns one sector byte into up to two result items.
// ----------------------------------------------------------------------------
module frls_parse #(
	parameter int SECTOR_BYTES = frls_pkg::SECTOR_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [7:0]       data_byte,
	input  logic             first,
	input  logic             big_endian,
	output frls_pkg::push_t  push
);
	import frls_pkg::*;

	localparam int POS_W = $clog2(SECTOR_BYTES + 1);
	localparam logic [31:0] SECT32 = 32'(SECTOR_BYTES);

	typedef enum logic [1:0] {PH_HEADER, PH_BODY, PH_STOP} phase_t;

	phase_t             phase_q, phase, phase_n;
	logic [POS_W-1:0]   pos_q, pos, pos_n;
	logic [POS_W-1:0]   rec_q, rec, rec_n;
	logic [31:0]        size_q, size, size_n;
	logic [1:0]         hdr_q, hdr, hdr_n;
	logic [POS_W-1:0]   key_q, key, key_n;
	logic               done_q, done, done_n;
	logic [31:0]        pos32, rec32, nrec32, vlen;

	function automatic res_t mk_res(kind_t k, logic [31:0] off, logic [31:0] klen,
			logic [31:0] vl, logic emp, logic [31:0] fr);
		res_t r;
		r.kind          = k;
		r.record_offset = off[OUT_W-1:0];
		r.key_length    = klen[OUT_W-1:0];
		r.value_length  = vl[OUT_W-1:0];
		r.removed       = emp;
		r.free_bytes    = fr[OUT_W-1:0];
		r.last          = 1'b0;
		return r;
	endfunction

	always_comb begin
		phase = first ? PH_HEADER : phase_q;
		pos   = first ? '0 : pos_q;
		rec   = first ? '0 : rec_q;
		size  = first ? '0 : size_q;
		hdr   = first ? '0 : hdr_q;
		key   = first ? '0 : key_q;
		done  = first ? 1'b0 : done_q;

		phase_n = phase;
		pos_n   = pos;
		rec_n   = rec;
		size_n  = size;
		hdr_n   = hdr;
		key_n   = key;
		done_n  = done;

		pos32  = 32'(pos);
		rec32  = 32'(rec);
		nrec32 = pos32 + 32'd1;
		vlen   = '0;
		push   = '0;

		if (phase == PH_STOP || pos32 >= SECT32) begin
			phase_n = PH_STOP;
		end else begin
			pos_n = pos + POS_W'(1);
			if (phase == PH_HEADER) begin
				if (hdr == 2'd0 && pos32 + 32'(HDR_BYTES) > SECT32) begin
					phase_n = PH_STOP;
					push.v0 = 1'b1;
					push.r0 = mk_res(KIND_CORRUPT, rec32, '0, '0, 1'b0, SECT32 - rec32);
				end else begin
					if (big_endian)
						size_n = ((hdr == 2'd0) ? 32'd0 : size) << 8 | 32'(data_byte);
					else
						size_n = ((hdr == 2'd0) ? 32'd0 : size)
							| (32'(data_byte) << {hdr, 3'b000});
					hdr_n = hdr + 2'd1;
					if (hdr == 2'd3) begin
						if (size_n == END_WORD) begin
							phase_n = PH_STOP;
							push.v0 = 1'b1;
							push.r0 = mk_res(KIND_END, rec32, '0, '0, 1'b0, SECT32 - rec32);
						end else if (rec32 + 32'(HDR_BYTES + MIN_KEY) > SECT32
								|| size_n > SECT32 - rec32
								|| size_n <= 32'(HDR_BYTES)) begin
							phase_n = PH_STOP;
							push.v0 = 1'b1;
							push.r0 = mk_res(KIND_CORRUPT, rec32, '0, '0, 1'b0,
								SECT32 - rec32);
						end else begin
							phase_n = PH_BODY;
							key_n   = '0;
							done_n  = 1'b0;
						end
					end
				end
			end else begin
				if (!done) begin
					key_n  = key + POS_W'(1);
					done_n = (data_byte == 8'd0);
				end
				if (pos32 - rec32 + 32'd1 == size) begin
					if (!done_n) begin
						phase_n = PH_STOP;
						push.v0 = 1'b1;
						push.r0 = mk_res(KIND_CORRUPT, rec32, '0, '0, 1'b0, SECT32 - rec32);
					end else begin
						vlen    = size - 32'(HDR_BYTES) - 32'(key_n);
						push.v0 = 1'b1;
						push.r0 = mk_res(KIND_RECORD, rec32, 32'(key_n), vlen,
							vlen == 32'd0, '0);
						rec_n   = pos + POS_W'(1);
						phase_n = PH_HEADER;
						hdr_n   = 2'd0;
						if (nrec32 >= SECT32) begin
							phase_n = PH_STOP;
							push.v1 = 1'b1;
							push.r1 = mk_res(KIND_END, nrec32, '0, '0, 1'b0,
								SECT32 - nrec32);
						end
					end
				end
			end
		end

		if (push.v1)
			push.r1.last = 1'b1;
		else
			push.r0.last = push.v0;

		if (!en)
			push = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			rec_q   <= '0;
			size_q  <= '0;
			hdr_q   <= '0;
			key_q   <= '0;
			done_q  <= 1'b0;
		end else if (en) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			rec_q   <= rec_n;
			size_q  <= size_n;
			hdr_q   <= hdr_n;
			key_q   <= key_n;
			done_q  <= done_n;
		end
	end

endmodule

### rtl/frls_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Small register queue taking up to two result items a cycle, one out.
// ----------------------------------------------------------------------------
module frls_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  frls_pkg::push_t  push,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output frls_pkg::res_t   out_item
);
	import frls_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	res_t               mem_q [QDEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         n_push;
	logic               pop;

	assign n_push    = {1'b0, push.v0} + {1'b0, push.v1};
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_item  = mem_q[rd_q];
	assign room      = (cnt_q <= CNT_W'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.v0)
			mem_q[wr_q] <= push.r0;
		if (push.v1)
			mem_q[wr_q + PTR_W'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(n_push);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

endmodule

### rtl/flash_record_log_scanner.sv
`timescale 1ns / 1ps
// A byte is parsed from the input register; its items are queued, then offered.
// Throughput: one byte per cycle; results leave at one item per cycle while
// m_axis_tready is high, through a four-entry result queue, and a byte is held
// in the input register while that queue lacks room for two items.
// Reset: asynchronous, active low; scan restarts at offset 0, big_endian is 1.
// ----------------------------------------------------------------------------
// Flash record log scanner
// Parses a flash sector byte stream as key-value records, reports each, and
// reports the end word or corruption that stops the scan.
module flash_record_log_scanner #(
	parameter int SECTOR_BYTES = frls_pkg::SECTOR_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,     // big_endian
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // data_byte
	input  logic                          s_axis_tuser,  // first
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// record_offset, key_length, value_length, removed, free_bytes, zero pad
	output logic [frls_pkg::TDATA_W-1:0]  m_axis_tdata,
	output logic [1:0]                    m_axis_tuser,  // kind
	output logic                          m_axis_tlast   // last
);
	import frls_pkg::*;

	logic        big_endian_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        room;
	push_t       push;
	res_t        head;

	assign s_axis_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b1;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_we)
				big_endian_q <= cfg_wdata;
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			first_s1 <= s_axis_tuser;
		end
	end

	frls_parse #(
		.SECTOR_BYTES(SECTOR_BYTES)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (valid_s1 && room),
		.data_byte  (byte_s1),
		.first      (first_s1),
		.big_endian (big_endian_q),
		.push       (push)
	);

	frls_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (head)
	);

	assign m_axis_tdata = {3'b000, head.free_bytes, head.removed, head.value_length,
		head.key_length, head.record_offset};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

endmodule

### rtl/frls_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanner port checker
// Watches the result stream of the scanner and flags malformed items.
// ----------------------------------------------------------------------------
module frls_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [frls_pkg::TDATA_W-1:0]  m_axis_tdata,
	input logic [1:0]                    m_axis_tuser,
	input logic                          m_axis_tlast
);
	import frls_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result item changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser == KIND_RECORD || m_axis_tuser == KIND_END
			|| m_axis_tuser == KIND_CORRUPT)
		else $error("bad result kind");

	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_RECORD
			|-> m_axis_tlast && m_axis_tdata[39:13] == '0)
		else $error("stop item carries record fields or is not last");

	a_record: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_RECORD
			|-> m_axis_tdata[52:40] == '0 && m_axis_tdata[25:13] != '0
				&& m_axis_tdata[39] == (m_axis_tdata[38:26] == '0))
		else $error("inconsistent record item");

endmodule

bind flash_record_log_scanner frls_checker u_chk (.*);
